// ===== rtl/hmtv_pkg.sv =====
package hmtv_pkg;

    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int COUNT_CAP = 2047;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [2:0] {
        PH_BETWEEN = 3'd0,
        PH_SIGN    = 3'd1,
        PH_DIGITS  = 3'd2,
        PH_COMMA   = 3'd3,
        PH_ZERO    = 3'd4,
        PH_HEX     = 3'd5,
        PH_IGNORE  = 3'd6
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_TOKEN = 2'd1,
        ST_WIDTH = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   map_width;
        logic [COUNT_W-1:0]   map_height;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   close;
        logic   bad;
    } t_scan;

    typedef struct packed {
        logic                 bad;
        logic [COUNT_W-1:0]   width;
        logic [COUNT_W-1:0]   rows;
    } t_finish;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    // start of a new token (or whitespace) from the between-tokens phase
    function automatic t_scan scan_between(logic [7:0] c);
        t_scan r;
        r.phase = PH_BETWEEN;
        r.close = 1'b0;
        r.bad   = 1'b0;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            r.phase = PH_BETWEEN;
        end else if (c == CH_NUL) begin
            r.phase = PH_IGNORE;
        end else if (c == CH_MINUS || c == CH_PLUS) begin
            r.phase = PH_SIGN;
        end else if (is_digit(c)) begin
            r.phase = PH_DIGITS;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic t_scan scan_byte(t_phase ph, logic [7:0] c);
        t_scan r;
        r.phase = ph;
        r.close = 1'b0;
        r.bad   = 1'b0;
        case (ph)
            PH_BETWEEN: begin
                r = scan_between(c);
            end
            PH_SIGN: begin
                if (is_digit(c)) r.phase = PH_DIGITS;
                else             r.bad   = 1'b1;
            end
            PH_DIGITS: begin
                if (c == CH_COMMA) begin
                    r.phase = PH_COMMA;
                end else if (!is_digit(c)) begin
                    r = scan_between(c);
                    r.close = 1'b1;
                end
            end
            PH_COMMA: begin
                if (c == CH_0) r.phase = PH_ZERO;
                else           r.bad   = 1'b1;
            end
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) r.phase = PH_HEX;
                else                          r.bad   = 1'b1;
            end
            PH_HEX: begin
                if (!is_hex(c)) begin
                    r = scan_between(c);
                    r.close = 1'b1;
                end
            end
            default: begin
                r.phase = ph;
            end
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v, logic inc,
                                                 logic [COUNT_W-1:0] cap);
        return (inc && v < cap) ? v + 1'b1 : v;
    endfunction

    function automatic t_finish finish_line(logic [COUNT_W-1:0] rows,
                                            logic [COUNT_W-1:0] width,
                                            logic [COUNT_W-1:0] cols,
                                            logic [COUNT_W-1:0] row_cap);
        t_finish r;
        r.bad   = 1'b0;
        r.width = width;
        r.rows  = sat_inc(rows, 1'b1, row_cap);
        if (rows == '0) begin
            r.width = cols;
        end else if (cols != width) begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hmtv_if.sv =====
interface hmtv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_file;

    modport source (output valid, output text_byte, output has_byte,
                    output end_of_file, input ready);
    modport sink   (input valid, input text_byte, input has_byte,
                    input end_of_file, output ready);
endinterface

interface hmtv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [10:0] map_width;
    logic [10:0] map_height;

    modport source (output valid, output status, output map_width,
                    output map_height, input ready);
    modport sink   (input valid, input status, input map_width,
                    input map_height, output ready);
endinterface

// ===== rtl/hmtv_in_stage.sv =====
module hmtv_in_stage
    import hmtv_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/hmtv_core.sv =====
module hmtv_core
    import hmtv_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int COL_LIM = (MAX_COLUMNS > COUNT_CAP) ? COUNT_CAP : MAX_COLUMNS;
    localparam int ROW_LIM = (MAX_ROWS > COUNT_CAP) ? COUNT_CAP : MAX_ROWS;
    localparam logic [COUNT_W-1:0] COL_CAP = COUNT_W'(COL_LIM);
    localparam logic [COUNT_W-1:0] ROW_CAP = COUNT_W'(ROW_LIM);

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_col, n_col;
    logic [COUNT_W-1:0] r_width, n_width;
    logic [COUNT_W-1:0] r_row, n_row;
    logic               r_open, n_open;
    t_status            r_err, n_err;

    logic               r_res_valid;
    t_result            r_res, n_res;

    t_scan              sc1, sc2;
    t_finish            fin1, fin2;
    logic [COUNT_W-1:0] col1, col2;
    t_status            res_err;
    logic               fire;

    // only a closing beat has to wait for the result register
    assign o_ready     = !(i_item.end_of_file && r_res_valid && !i_res_ready);
    assign fire        = i_valid && o_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_phase = r_phase;
        n_col   = r_col;
        n_width = r_width;
        n_row   = r_row;
        n_open  = r_open;
        n_err   = r_err;

        sc1  = scan_byte(r_phase, i_item.text_byte);
        col1 = sat_inc(r_col, sc1.close, COL_CAP);
        fin1 = finish_line(r_row, r_width, col1, ROW_CAP);

        if (i_item.has_byte && r_err == ST_OK) begin
            if (sc1.bad) begin
                n_err = ST_TOKEN;
            end else if (i_item.text_byte == CH_NL) begin
                if (fin1.bad) begin
                    n_err = ST_WIDTH;
                end else begin
                    n_width = fin1.width;
                    n_row   = fin1.rows;
                    n_col   = '0;
                    n_phase = PH_BETWEEN;
                    n_open  = 1'b0;
                end
            end else begin
                n_phase = sc1.phase;
                n_col   = col1;
                n_open  = 1'b1;
            end
        end

        // an unterminated last line closes as if by a zero byte
        sc2  = scan_byte(n_phase, CH_NUL);
        col2 = sat_inc(n_col, sc2.close, COL_CAP);
        fin2 = finish_line(n_row, n_width, col2, ROW_CAP);

        res_err          = n_err;
        n_res.map_width  = n_width;
        n_res.map_height = n_row;
        if (n_err == ST_OK && n_open) begin
            if (sc2.bad) begin
                res_err = ST_TOKEN;
            end else if (fin2.bad) begin
                res_err = ST_WIDTH;
            end else begin
                n_res.map_width  = fin2.width;
                n_res.map_height = fin2.rows;
            end
        end

        if (res_err != ST_OK)          n_res.status = res_err;
        else if (n_res.map_height == '0) n_res.status = ST_EMPTY;
        else                           n_res.status = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BETWEEN;
            r_col       <= '0;
            r_width     <= '0;
            r_row       <= '0;
            r_open      <= 1'b0;
            r_err       <= ST_OK;
            r_res_valid <= 1'b0;
        end else begin
            if (fire && i_item.end_of_file) begin
                r_phase     <= PH_BETWEEN;
                r_col       <= '0;
                r_width     <= '0;
                r_row       <= '0;
                r_open      <= 1'b0;
                r_err       <= ST_OK;
                r_res_valid <= 1'b1;
            end else begin
                if (fire) begin
                    r_phase <= n_phase;
                    r_col   <= n_col;
                    r_width <= n_width;
                    r_row   <= n_row;
                    r_open  <= n_open;
                    r_err   <= n_err;
                end
                if (i_res_ready) begin
                    r_res_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && i_item.end_of_file) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== rtl/height_map_text_validator.sv =====
// Height-map text checker. Takes the map text one byte per beat on i_in and
// returns one beat on o_out (status, map_width, map_height) for each beat
// marked end_of_file; other beats give nothing. Status: 0 ok, 1 bad token,
// 2 rows of unequal token count, 3 empty file. The first error is kept and
// the counts freeze there. After the end-of-file beat the block starts over
// for the next file. Rate is one beat per clock while the input is not stalled.
// A closing beat lands in the input register when it is taken. When the core
// takes it from there, the parse/count update loads the result register,
// which drives o_out. The input stalls only while a closing beat is held back
// because the previous result is still waiting at o_out.
module height_map_text_validator
    import hmtv_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmtv_in_if.sink    i_in,
    hmtv_out_if.source o_out
);

    t_item   in_item;
    t_item   stg_item;
    logic    stg_valid;
    logic    core_ready;
    t_result res;

    assign in_item.text_byte   = i_in.text_byte;
    assign in_item.has_byte    = i_in.has_byte;
    assign in_item.end_of_file = i_in.end_of_file;

    hmtv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (in_item),
        .o_valid (stg_valid),
        .i_ready (core_ready),
        .o_item  (stg_item)
    );

    hmtv_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid),
        .o_ready     (core_ready),
        .i_item      (stg_item),
        .o_res_valid (o_out.valid),
        .i_res_ready (o_out.ready),
        .o_res       (res)
    );

    assign o_out.status     = res.status;
    assign o_out.map_width  = res.map_width;
    assign o_out.map_height = res.map_height;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench
    import hmtv_pkg::*;
();

    localparam int MAX_COLS       = 1024;
    localparam int MAX_LINES      = 1024;
    localparam int COL_CAP        = (MAX_COLS > COUNT_CAP) ? COUNT_CAP : MAX_COLS;
    localparam int ROW_CAP        = (MAX_LINES > COUNT_CAP) ? COUNT_CAP : MAX_LINES;
    localparam int RANDOM_BEATS   = 480;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam longint TIMEOUT_NS = 200_000;

    localparam string HEX_CHARS = "0123456789abcdefABCDEF";
    localparam logic [7:0] BLANKS [5] = '{CH_SPACE, CH_TAB, 8'h0B, 8'h0C, CH_CR};

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmtv_in_if  in_if ();
    hmtv_out_if out_if ();

    height_map_text_validator #(
        .MAX_COLUMNS (MAX_COLS),
        .MAX_ROWS    (MAX_LINES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shape tracker state
    t_phase             tok_phase;
    logic [COUNT_W-1:0] line_tokens;
    logic [COUNT_W-1:0] first_width;
    logic [COUNT_W-1:0] lines_done;
    logic               line_open;
    t_status            first_err;

    t_result    expected_shapes[$];
    logic [7:0] file_text[$];
    int         mismatches = 0;
    bit         steady = 1'b0;
    bit         rx_hold = 1'b0;
    event       hold_rx_ev;

    function automatic void clear_shape_state();
        tok_phase   = PH_BETWEEN;
        line_tokens = '0;
        first_width = '0;
        lines_done  = '0;
        line_open   = 1'b0;
        first_err   = ST_OK;
    endfunction

    function automatic bit dec_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit hex_digit(logic [7:0] c);
        return dec_digit(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic void flag(t_status s);
        if (first_err == ST_OK) first_err = s;
    endfunction

    function automatic void count_token();
        if (line_tokens < COL_CAP) line_tokens++;
        tok_phase = PH_BETWEEN;
    endfunction

    function automatic void start_token(logic [7:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
        if (c == CH_NUL) tok_phase = PH_IGNORE;
        else if (c == CH_MINUS || c == CH_PLUS) tok_phase = PH_SIGN;
        else if (dec_digit(c)) tok_phase = PH_DIGITS;
        else flag(ST_TOKEN);
    endfunction

    function automatic void feed_char(logic [7:0] c);
        case (tok_phase)
            PH_BETWEEN: start_token(c);
            PH_SIGN: begin
                if (dec_digit(c)) tok_phase = PH_DIGITS;
                else flag(ST_TOKEN);
            end
            PH_DIGITS: begin
                if (c == CH_COMMA) begin
                    tok_phase = PH_COMMA;
                end else if (!dec_digit(c)) begin
                    // byte that ends the number starts whatever follows
                    count_token();
                    start_token(c);
                end
            end
            PH_COMMA: begin
                if (c == CH_0) tok_phase = PH_ZERO;
                else flag(ST_TOKEN);
            end
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) tok_phase = PH_HEX;
                else flag(ST_TOKEN);
            end
            PH_HEX: begin
                if (!hex_digit(c)) begin
                    count_token();
                    start_token(c);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void end_line();
        if (first_err != ST_OK) return;
        if (lines_done == 0) begin
            first_width = line_tokens;
        end else if (line_tokens != first_width) begin
            flag(ST_WIDTH);
            return;
        end
        if (lines_done < ROW_CAP) lines_done++;
        line_tokens = '0;
        tok_phase   = PH_BETWEEN;
        line_open   = 1'b0;
    endfunction

    function automatic void predict_map_shape(logic [7:0] c, logic has, logic eof);
        t_result shape;
        if (has && first_err == ST_OK) begin
            feed_char(c);
            if (first_err == ST_OK) begin
                if (c == CH_NL) end_line();
                else line_open = 1'b1;
            end
        end
        if (eof) begin
            // unterminated last line closes as if a zero byte came
            if (first_err == ST_OK && line_open) begin
                feed_char(CH_NUL);
                end_line();
            end
            if (first_err != ST_OK) shape.status = first_err;
            else if (lines_done == 0) shape.status = ST_EMPTY;
            else shape.status = ST_OK;
            shape.map_width  = first_width;
            shape.map_height = lines_done;
            expected_shapes.push_back(shape);
            clear_shape_state();
        end
    endfunction

    task automatic send_beat(logic [7:0] c, logic has, logic eof);
        bit took;
        if (!steady && $urandom_range(99) < 17) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.text_byte   <= c;
        in_if.has_byte    <= has;
        in_if.end_of_file <= eof;
        do begin
            @(negedge i_clk);
            took = in_if.ready;
            @(posedge i_clk);
        end while (!took);
        predict_map_shape(c, has, eof);
    endtask

    // sends file_text; the closing mark rides on the last byte or on a bare beat
    task automatic send_file(bit bare_end);
        foreach (file_text[i]) begin
            if ($urandom_range(19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(file_text[i], 1'b1, !bare_end && i == file_text.size() - 1);
        end
        if (bare_end || file_text.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) file_text.push_back(s[i]);
    endfunction

    function automatic void push_blank();
        file_text.push_back(BLANKS[$urandom_range(4)]);
    endfunction

    function automatic void push_line(int n, bit is_last);
        int sign;
        if ($urandom_range(5) == 0) push_blank();
        for (int t = 0; t < n; t++) begin
            sign = $urandom_range(3);
            // a signed token may butt right against the previous one
            if (t > 0 && !(sign >= 2 && $urandom_range(2) == 0)) push_blank();
            if (sign == 2) file_text.push_back(CH_MINUS);
            else if (sign == 3) file_text.push_back(CH_PLUS);
            repeat ($urandom_range(1, 3)) file_text.push_back(8'(CH_0 + $urandom_range(9)));
            if ($urandom_range(3) == 0) begin
                file_text.push_back(CH_COMMA);
                file_text.push_back(CH_0);
                file_text.push_back($urandom_range(1) ? CH_LX : CH_UX);
                repeat ($urandom_range(3)) file_text.push_back(HEX_CHARS[$urandom_range(21)]);
            end
        end
        if ($urandom_range(7) == 0) push_blank();
        if ($urandom_range(9) == 0) begin
            file_text.push_back(CH_NUL);
            file_text.push_back(8'($urandom));
        end
        if (!is_last || $urandom_range(3) != 0) begin
            if ($urandom_range(4) == 0) file_text.push_back(CH_CR);
            file_text.push_back(CH_NL);
        end
    endfunction

    function automatic void build_random_file();
        int kind;
        int cols;
        int rows;
        int n;
        file_text.delete();
        kind = $urandom_range(99);
        if (kind < 3) return;
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) file_text.push_back(8'($urandom));
            return;
        end
        cols = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
        rows = $urandom_range(1, 4);
        if (kind < 22 && rows < 2) rows = 2;
        for (int r = 0; r < rows; r++) begin
            n = cols;
            if (kind < 22 && r == rows - 1)
                n = (cols == 0) ? 1 : cols + ($urandom_range(1) ? 1 : -1);
            push_line(n, r == rows - 1);
        end
        if (kind < 34 && kind >= 22)
            file_text[$urandom_range(file_text.size() - 1)] = 8'($urandom);
    endfunction

    task automatic test_empty_file();
        file_text.delete();
        send_file(1'b1);
    endtask

    task automatic test_token_forms();
        // adjacent tokens, hex suffix, unterminated last line
        file_text.delete();
        push_text("1-2,0xF\n+3 4");
        send_file(1'b0);
        file_text.delete();
        push_text("+0,0X9aB\t-5\r\n");
        send_file(1'b1);
    endtask

    task automatic test_bad_tokens();
        // zero byte ends the token and hides the rest of the line, then a bad token sticks
        file_text.delete();
        push_text("7");
        file_text.push_back(CH_NUL);
        push_text("q\nz\n1");
        send_file(1'b0);
        file_text.delete();
        push_text("1\n2 3\n");
        send_file(1'b0);
        // dangling "0" after comma at end of text
        file_text.delete();
        push_text("5,0");
        send_file(1'b0);
        file_text.delete();
        file_text.push_back(8'hFF);
        send_file(1'b1);
    endtask

    task automatic test_random_files();
        int sent;
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            steady = (sent >= 150 && sent < 300);
            build_random_file();
            send_file(file_text.size() == 0 || $urandom_range(3) == 0);
            sent += file_text.size();
        end
        steady = 1'b0;
    endtask

    task automatic test_receiver_hold_off();
        steady = 1'b1;
        -> hold_rx_ev;
        repeat (40) begin
            file_text.delete();
            push_text("3 4\n");
            send_file($urandom_range(1));
        end
        steady = 1'b0;
    endtask

    initial begin
        forever begin
            @(hold_rx_ev);
            rx_hold = 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold) out_if.ready <= 1'b0;
        else if (steady) out_if.ready <= 1'b1;
        else out_if.ready <= ($urandom_range(99) >= 15);
    end

    // inputs only move at the rising edge, so the falling edge sees stable values
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_shapes.size() == 0) begin
                $error("unexpected result: status %0d width %0d height %0d",
                       out_if.status, out_if.map_width, out_if.map_height);
                mismatches++;
            end else begin
                want = expected_shapes.pop_front();
                if (out_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_if.status);
                    mismatches++;
                end
                if (out_if.map_width !== want.map_width) begin
                    $error("map_width: expected %0d, actual %0d",
                           want.map_width, out_if.map_width);
                    mismatches++;
                end
                if (out_if.map_height !== want.map_height) begin
                    $error("map_height: expected %0d, actual %0d",
                           want.map_height, out_if.map_height);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $error("run timed out with %0d results pending", expected_shapes.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.text_byte   = '0;
        in_if.has_byte    = 1'b0;
        in_if.end_of_file = 1'b0;
        out_if.ready      = 1'b0;
        clear_shape_state();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_file();
        test_token_forms();
        test_bad_tokens();
        test_random_files();
        test_receiver_hold_off();
        in_if.valid <= 1'b0;

        waited = 0;
        while (expected_shapes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_shapes.size() != 0) begin
            $error("%0d expected results never arrived", expected_shapes.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
